[rtl/core/toeq_pkg.sv]
// ----------------------------------------------------------------------------
// toeq_pkg: shared definitions for the time ordered event queue
// Status codes, request codes, default sizes and the per-cycle command that
// the top level broadcasts to every cell of the sorted chain.
// ----------------------------------------------------------------------------
`default_nettype none

package toeq_pkg;

  // Default sizes.
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TimeBitsDef   = 32;
  localparam int unsigned IdBitsDef     = 16;

  // Width of the entry_count result field.
  localparam int unsigned CountOutBits = 5;

  // Request codes carried on req_type.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Command broadcast to all cells in the cycle a beat is accepted.
  // Both bits are already qualified: ins only when not full, pop only when
  // not empty.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_cmd_t;

endpackage : toeq_pkg

`default_nettype wire

[rtl/core/toeq_cell.sv]
// ----------------------------------------------------------------------------
// toeq_cell: one slot of the sorted event chain
// Holds one entry, tells its successor whether its entry sorts after the
// incoming time, and loads from its neighbors or the new event on shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module toeq_cell #(
  parameter int unsigned TIME_BITS = toeq_pkg::TimeBitsDef,
  parameter int unsigned ID_BITS   = toeq_pkg::IdBitsDef
) (
  input  wire                     clk_i,
  input  toeq_pkg::cell_cmd_t     cmd_i,
  input  wire                     valid_i,
  input  wire  [TIME_BITS-1:0]    new_time_i,
  input  wire  [ID_BITS-1:0]      new_id_i,
  input  wire                     prev_later_i,
  input  wire  [TIME_BITS-1:0]    prev_time_i,
  input  wire  [ID_BITS-1:0]      prev_id_i,
  input  wire  [TIME_BITS-1:0]    next_time_i,
  input  wire  [ID_BITS-1:0]      next_id_i,
  output logic                    later_o,
  output logic [TIME_BITS-1:0]    time_o,
  output logic [ID_BITS-1:0]      id_o,
  output logic [TIME_BITS-1:0]    time_d_o,
  output logic [ID_BITS-1:0]      id_d_o
);

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [ID_BITS-1:0]   id_q, id_d;

  // An empty slot counts as later than any new time, so the new entry lands
  // in the first empty slot when no stored entry is later.
  assign later_o = !valid_i || (new_time_i < time_q);

  always_comb begin
    time_d = time_q;
    id_d   = id_q;
    if (cmd_i.ins && later_o) begin
      if (prev_later_i) begin
        time_d = prev_time_i;
        id_d   = prev_id_i;
      end else begin
        time_d = new_time_i;
        id_d   = new_id_i;
      end
    end else if (cmd_i.pop) begin
      time_d = next_time_i;
      id_d   = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    id_q   <= id_d;
  end

  assign time_o   = time_q;
  assign id_o     = id_q;
  assign time_d_o = time_d;
  assign id_d_o   = id_d;

endmodule : toeq_cell

`default_nettype wire

[rtl/core/time_ordered_event_queue.sv]
// ----------------------------------------------------------------------------
// time_ordered_event_queue: bounded event queue kept in ascending time order
// A chain of cells, slot 0 the head, that shifts as one on insert or remove.
// ----------------------------------------------------------------------------
// Usage: the request channel (in_valid_i / in_stall_o) carries one beat per
// request. req_type_i selects insert (event_time_i, event_id_i are stored in
// front of the first entry with a strictly later time) or remove of the
// head. Each request produces exactly one result beat on the result channel
// (out_valid_o / out_stall_i) with the status, the popped entry, the new head
// and the new entry count.
// The result is registered: the result of a beat accepted at one edge is
// shown from the next edge on. Throughput is one beat per cycle while the
// result is not stalled; every cell compares the new time against its own
// entry in parallel and the whole chain shifts in the same cycle, so the
// compare in each cell is the only work per beat.
// The result sits in one output register. While it is stalled a new request
// is held off, since its result would have nowhere to go; when the receiver
// takes the waiting result, a new request is taken in the same cycle.
// Reset empties the queue (count zero) and clears the result valid; slot
// contents are not cleared, as only slots below the count are ever read.
// An insert into a full queue reports STATUS_FULL and a remove from an empty
// queue reports STATUS_EMPTY; neither changes the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module time_ordered_event_queue #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::QueueDepthDef,
  parameter int unsigned TIME_BITS   = toeq_pkg::TimeBitsDef,
  parameter int unsigned ID_BITS     = toeq_pkg::IdBitsDef
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Request channel.
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire                                   req_type_i,
  input  wire  [TIME_BITS-1:0]                  event_time_i,
  input  wire  [ID_BITS-1:0]                    event_id_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [1:0]                            status_o,
  output logic [TIME_BITS-1:0]                  popped_time_o,
  output logic [ID_BITS-1:0]                    popped_id_o,
  output logic [TIME_BITS-1:0]                  head_time_o,
  output logic [ID_BITS-1:0]                    head_id_o,
  output logic [toeq_pkg::CountOutBits-1:0]     entry_count_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // Occupancy and the result register.
  logic [CntW-1:0]                  count_q, count_d;
  logic                             out_valid_q, out_valid_d;
  toeq_pkg::status_e                status_q, status_d;
  logic [TIME_BITS-1:0]             popped_time_q, popped_time_d;
  logic [ID_BITS-1:0]               popped_id_q, popped_id_d;
  logic [TIME_BITS-1:0]             head_time_q, head_time_d;
  logic [ID_BITS-1:0]               head_id_q, head_id_d;

  logic                             accept;
  logic                             is_full, is_empty;
  toeq_pkg::cell_cmd_t              cmd;

  // Per-cell chain signals.
  logic [QUEUE_DEPTH-1:0]           later;
  logic [TIME_BITS-1:0]             cell_time   [QUEUE_DEPTH];
  logic [ID_BITS-1:0]               cell_id     [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]             cell_time_d [QUEUE_DEPTH];
  logic [ID_BITS-1:0]               cell_id_d   [QUEUE_DEPTH];

  // A new beat can enter whenever the result register is free or is being
  // emptied in this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CntW'(QUEUE_DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    cmd.ins = accept && (req_type_i == toeq_pkg::REQ_INSERT) && !is_full;
    cmd.pop = accept && (req_type_i == toeq_pkg::REQ_REMOVE) && !is_empty;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 prev_later;
    logic [TIME_BITS-1:0] prev_time;
    logic [ID_BITS-1:0]   prev_id;
    logic [TIME_BITS-1:0] next_time;
    logic [ID_BITS-1:0]   next_id;

    // The head has no predecessor, so it always takes the new entry when
    // its own entry is later. The tail keeps its entry on a remove; that
    // slot falls out of the valid range anyway.
    if (i == 0) begin : g_first
      assign prev_later = 1'b0;
      assign prev_time  = event_time_i;
      assign prev_id    = event_id_i;
    end else begin : g_inner
      assign prev_later = later[i-1];
      assign prev_time  = cell_time[i-1];
      assign prev_id    = cell_id[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_time = cell_time[i];
      assign next_id   = cell_id[i];
    end else begin : g_body
      assign next_time = cell_time[i+1];
      assign next_id   = cell_id[i+1];
    end

    toeq_cell #(
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (ID_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .valid_i      (CntW'(i) < count_q),
      .new_time_i   (event_time_i),
      .new_id_i     (event_id_i),
      .prev_later_i (prev_later),
      .prev_time_i  (prev_time),
      .prev_id_i    (prev_id),
      .next_time_i  (next_time),
      .next_id_i    (next_id),
      .later_o      (later[i]),
      .time_o       (cell_time[i]),
      .id_o         (cell_id[i]),
      .time_d_o     (cell_time_d[i]),
      .id_d_o       (cell_id_d[i])
    );
  end

  // Next occupancy and the result of the accepted beat. The new head is the
  // next value of slot 0.
  always_comb begin
    count_d       = count_q;
    out_valid_d   = out_valid_q && out_stall_i;
    status_d      = status_q;
    popped_time_d = popped_time_q;
    popped_id_d   = popped_id_q;
    head_time_d   = head_time_q;
    head_id_d     = head_id_q;

    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CntW'(1);
    end

    if (accept) begin
      out_valid_d   = 1'b1;
      status_d      = toeq_pkg::STATUS_OK;
      popped_time_d = '0;
      popped_id_d   = '0;
      if (req_type_i == toeq_pkg::REQ_INSERT) begin
        if (is_full) begin
          status_d = toeq_pkg::STATUS_FULL;
        end
      end else begin
        if (is_empty) begin
          status_d = toeq_pkg::STATUS_EMPTY;
        end else begin
          popped_time_d = cell_time[0];
          popped_id_d   = cell_id[0];
        end
      end
      if (count_d == '0) begin
        head_time_d = '0;
        head_id_d   = '0;
      end else begin
        head_time_d = cell_time_d[0];
        head_id_d   = cell_id_d[0];
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    status_q      <= status_d;
    popped_time_q <= popped_time_d;
    popped_id_q   <= popped_id_d;
    head_time_q   <= head_time_d;
    head_id_q     <= head_id_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign popped_time_o = popped_time_q;
  assign popped_id_o   = popped_id_q;
  assign head_time_o   = head_time_q;
  assign head_id_o     = head_id_q;

  // The count field is the occupancy taken to the field's width.
  if (CntW >= toeq_pkg::CountOutBits) begin : g_cnt_trunc
    assign entry_count_o = count_q[toeq_pkg::CountOutBits-1:0];
  end else begin : g_cnt_ext
    assign entry_count_o = {{(toeq_pkg::CountOutBits - CntW){1'b0}}, count_q};
  end

endmodule : time_ordered_event_queue

`default_nettype wire
